### rtl/core/sc2a_pkg.sv
// Shared types, constants and angle table for the sine/cosine to angle unit.
package sc2a_pkg;

  localparam int DEF_STAGES      = 16;
  localparam int DEF_SAMPLE_BITS = 12;
  localparam int TABLE_LEN       = 24;
  localparam int WORK_SHIFT      = 20;
  localparam int ANGLE_FRAC      = 23;
  localparam int OUT_SHIFT       = 16;
  localparam int ANGLE_W         = 16;
  localparam int ANGLE_LIMIT     = 23040;
  localparam int ZW              = 33;

  localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(90 << ANGLE_FRAC);

  typedef struct packed {
    logic valid;
    logic zero;
  } ctl_t;

  // atan(2^-idx) in units of 2^-23 degree, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_step(input int unsigned idx);
    logic [63:0] ndeg;
    logic [63:0] scaled;
    case (idx)
      0:       ndeg = 64'd45000000000;
      1:       ndeg = 64'd26565051177;
      2:       ndeg = 64'd14036243468;
      3:       ndeg = 64'd7125016349;
      4:       ndeg = 64'd3576334375;
      5:       ndeg = 64'd1789910608;
      6:       ndeg = 64'd895173710;
      7:       ndeg = 64'd447614171;
      8:       ndeg = 64'd223810500;
      9:       ndeg = 64'd111905677;
      10:      ndeg = 64'd55952892;
      11:      ndeg = 64'd27976453;
      12:      ndeg = 64'd13988227;
      13:      ndeg = 64'd6994114;
      14:      ndeg = 64'd3497057;
      15:      ndeg = 64'd1748528;
      16:      ndeg = 64'd874264;
      17:      ndeg = 64'd437132;
      18:      ndeg = 64'd218566;
      19:      ndeg = 64'd109283;
      20:      ndeg = 64'd54642;
      21:      ndeg = 64'd27321;
      22:      ndeg = 64'd13660;
      23:      ndeg = 64'd6830;
      default: ndeg = 64'd0;
    endcase
    scaled = (ndeg << ANGLE_FRAC) + 64'd500000000;
    return ZW'(scaled / 64'd1000000000);
  endfunction

endpackage

### rtl/core/sc2a_front.sv
// Input stage: offset removal, zero detect and half-plane pre-rotation.
module sc2a_front import sc2a_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int XW          = DEF_SAMPLE_BITS + WORK_SHIFT + 3
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   take,
  input  logic [SAMPLE_BITS-1:0] sin_sample,
  input  logic [SAMPLE_BITS-1:0] cos_sample,
  input  logic [SAMPLE_BITS-1:0] mid_offset,
  output ctl_t                   ctl_o,
  output logic signed [XW-1:0]   x_o,
  output logic signed [XW-1:0]   y_o,
  output logic signed [ZW-1:0]   z_o
);

  localparam int SW = SAMPLE_BITS + 1;

  logic signed [SW-1:0] s_val;
  logic signed [SW-1:0] c_val;
  logic signed [SW-1:0] xs;
  logic signed [SW-1:0] ys;
  logic signed [ZW-1:0] z_nxt;
  logic signed [XW-1:0] x_r;
  logic signed [XW-1:0] y_r;
  logic signed [ZW-1:0] z_r;
  ctl_t                 ctl_r;

  assign s_val = signed'({1'b0, sin_sample}) - signed'({1'b0, mid_offset});
  assign c_val = signed'({1'b0, cos_sample}) - signed'({1'b0, mid_offset});

  always_comb begin
    if (c_val[SW-1] && !s_val[SW-1]) begin
      xs    = s_val;
      ys    = -c_val;
      z_nxt = Z_QUARTER;
    end else if (c_val[SW-1]) begin
      xs    = -s_val;
      ys    = c_val;
      z_nxt = -Z_QUARTER;
    end else begin
      xs    = c_val;
      ys    = s_val;
      z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r.valid <= take;
      ctl_r.zero  <= (s_val == '0) && (c_val == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      x_r <= {{(XW-SW-WORK_SHIFT){xs[SW-1]}}, xs, {WORK_SHIFT{1'b0}}};
      y_r <= {{(XW-SW-WORK_SHIFT){ys[SW-1]}}, ys, {WORK_SHIFT{1'b0}}};
      z_r <= z_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

### rtl/core/sc2a_stage.sv
// One registered CORDIC vectoring iteration.
module sc2a_stage import sc2a_pkg::*; #(
  parameter int XW    = DEF_SAMPLE_BITS + WORK_SHIFT + 3,
  parameter int STAGE = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctl_t                 ctl_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output ctl_t                 ctl_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);

  localparam logic signed [ZW-1:0] STEP_ANGLE = atan_step(STAGE);

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [XW-1:0] x_nxt;
  logic signed [XW-1:0] y_nxt;
  logic signed [ZW-1:0] z_nxt;
  logic signed [XW-1:0] x_r;
  logic signed [XW-1:0] y_r;
  logic signed [ZW-1:0] z_r;
  ctl_t                 ctl_r;

  assign dx = y_i >>> STAGE;
  assign dy = x_i >>> STAGE;

  always_comb begin
    if (!y_i[XW-1]) begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + STEP_ANGLE;
    end else begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - STEP_ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.valid) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign z_o   = z_r;

endmodule

### rtl/core/sc2a_back.sv
// Output stage: round the angle to 1/128 degree, saturate, and force zero for a zero vector.
module sc2a_back import sc2a_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ctl_t                      ctl_i,
  input  logic signed [ZW-1:0]      z_i,
  output logic                      strobe,
  output logic signed [ANGLE_W-1:0] angle
);

  localparam int RW = ZW + 1 - OUT_SHIFT;
  localparam logic signed [RW-1:0] LIM_HI = RW'(ANGLE_LIMIT);
  localparam logic signed [RW-1:0] LIM_LO = -RW'(ANGLE_LIMIT);

  logic signed [ZW:0]          z_rnd;
  logic signed [RW-1:0]        r_val;
  logic signed [ANGLE_W-1:0]   angle_nxt;
  logic signed [ANGLE_W-1:0]   angle_r;
  logic                        strobe_r;

  assign z_rnd = {z_i[ZW-1], z_i} + (ZW+1)'(1 << (OUT_SHIFT - 1));
  assign r_val = RW'(z_rnd >>> OUT_SHIFT);

  always_comb begin
    if (ctl_i.zero) begin
      angle_nxt = '0;
    end else if (r_val > LIM_HI) begin
      angle_nxt = ANGLE_W'(LIM_HI);
    end else if (r_val < LIM_LO) begin
      angle_nxt = ANGLE_W'(LIM_LO);
    end else begin
      angle_nxt = ANGLE_W'(r_val);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.valid) begin
      angle_r <= angle_nxt;
    end
  end

  assign strobe = strobe_r;
  assign angle  = angle_r;

endmodule

### rtl/core/sin_cos_to_angle_unit.sv
// Top level: pipelined CORDIC atan2 of a sine/cosine sample pair.
//
// Takes one sample pair per clock (start high while busy is low) and returns
// atan2(sin - mid_offset, cos - mid_offset) in 1/128 degree, -23040..23040, on
// out_angle_deg with out_strobe high for one cycle. Each pair passes through
// the front stage, one register per CORDIC iteration and the output stage;
// throughput is one beat per clock. Results cannot be held off
// by the receiver. busy is high only during reset and the first cycle after
// it. Write cfg_wdata with cfg_we only while no beat is in flight.
module sin_cos_to_angle_unit import sc2a_pkg::*; #(
  parameter int CORDIC_STAGES = DEF_STAGES,
  parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [SAMPLE_BITS-1:0]    in_sin_sample,
  input  logic [SAMPLE_BITS-1:0]    in_cos_sample,
  output logic                      out_strobe,
  output logic signed [ANGLE_W-1:0] out_angle_deg,
  input  logic                      cfg_we,
  input  logic [SAMPLE_BITS-1:0]    cfg_wdata
);

  localparam int XW  = SAMPLE_BITS + WORK_SHIFT + 3;
  localparam int LAT = CORDIC_STAGES + 2;

  logic                   busy_r;
  logic [SAMPLE_BITS-1:0] mid_offset_r;
  logic                   take;

  ctl_t                 ctl_p [CORDIC_STAGES+1];
  logic signed [XW-1:0] x_p   [CORDIC_STAGES+1];
  logic signed [XW-1:0] y_p   [CORDIC_STAGES+1];
  logic signed [ZW-1:0] z_p   [CORDIC_STAGES+1];

  assign take = start && !busy_r;
  assign busy = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      mid_offset_r <= SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        mid_offset_r <= cfg_wdata;
      end
    end
  end

  sc2a_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .XW          (XW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .sin_sample (in_sin_sample),
    .cos_sample (in_cos_sample),
    .mid_offset (mid_offset_r),
    .ctl_o      (ctl_p[0]),
    .x_o        (x_p[0]),
    .y_o        (y_p[0]),
    .z_o        (z_p[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    sc2a_stage #(
      .XW    (XW),
      .STAGE (i)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_p[i]),
      .x_i   (x_p[i]),
      .y_i   (y_p[i]),
      .z_i   (z_p[i]),
      .ctl_o (ctl_p[i+1]),
      .x_o   (x_p[i+1]),
      .y_o   (y_p[i+1]),
      .z_o   (z_p[i+1])
    );
  end

  sc2a_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl_p[CORDIC_STAGES]),
    .z_i    (z_p[CORDIC_STAGES]),
    .strobe (out_strobe),
    .angle  (out_angle_deg)
  );

  a_lat_hit: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ##LAT out_strobe)
    else $error("accepted beat did not produce a result at fixed latency");

  a_lat_none: assert property (@(posedge clk) disable iff (!rst_n)
    !take |-> ##LAT !out_strobe)
    else $error("result strobe without an accepted beat");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_angle_deg <= ANGLE_W'(ANGLE_LIMIT)) &&
                   (out_angle_deg >= -ANGLE_W'(ANGLE_LIMIT)))
    else $error("angle outside saturation limits");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_sin_sample == mid_offset_r && in_cos_sample == mid_offset_r)
      |-> ##LAT (out_angle_deg == '0))
    else $error("zero vector did not give zero angle");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for sin_cos_to_angle_unit: directed and random sample pairs.
module tb_top import sc2a_pkg::*; ();

  localparam int N_STAGES         = 16;
  localparam int S_BITS           = 12;
  localparam int LATENCY          = N_STAGES + 2;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int N_PHASES         = 8;
  localparam int ITEMS_PER_PHASE  = 250;
  localparam int N_DIR            = 20;
  localparam int FRAC_BITS        = 23;
  localparam int ROUND_SHIFT      = 16;
  localparam int PRESCALE         = 20;
  localparam int SAT_LIMIT        = 23040;

  typedef struct packed {
    logic [S_BITS-1:0]         sin_raw;
    logic [S_BITS-1:0]         cos_raw;
    logic                      typed;
    logic signed [ANGLE_W-1:0] angle;
  } dir_row_t;

  typedef struct packed {
    logic [S_BITS-1:0]         sin_raw;
    logic [S_BITS-1:0]         cos_raw;
    logic [S_BITS-1:0]         offset;
    logic signed [ANGLE_W-1:0] angle;
  } angle_rec_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic [S_BITS-1:0]         in_sin_sample = '0;
  logic [S_BITS-1:0]         in_cos_sample = '0;
  logic                      cfg_we = 1'b0;
  logic [S_BITS-1:0]         cfg_wdata = '0;
  logic                      busy;
  logic                      out_strobe;
  logic signed [ANGLE_W-1:0] out_angle_deg;

  // atan(2^-i) in nanodegrees
  longint unsigned atan_ndeg [N_STAGES] = '{
    64'd45000000000, 64'd26565051177, 64'd14036243468, 64'd7125016349,
    64'd3576334375,  64'd1789910608,  64'd895173710,   64'd447614171,
    64'd223810500,   64'd111905677,   64'd55952892,    64'd27976453,
    64'd13988227,    64'd6994114,     64'd3497057,     64'd1748528
  };

  dir_row_t dir_rows [N_DIR] = '{
    '{12'd2048, 12'd2048, 1'b1, 16'sd0},       // both at zero level
    '{12'd2048, 12'd0,    1'b1, 16'sd23040},   // negative cosine, zero sine
    '{12'd2048, 12'd4095, 1'b1, 16'sd0},
    '{12'd4095, 12'd2048, 1'b1, 16'sd11520},
    '{12'd0,    12'd2048, 1'b1, -16'sd11520},
    '{12'd4095, 12'd4095, 1'b1, 16'sd5760},
    '{12'd0,    12'd0,    1'b1, -16'sd17280},
    '{12'd4095, 12'd0,    1'b0, 16'sd0},
    '{12'd0,    12'd4095, 1'b0, 16'sd0},
    '{12'd2049, 12'd0,    1'b0, 16'sd0},
    '{12'd2047, 12'd0,    1'b0, 16'sd0},
    '{12'd2048, 12'd2047, 1'b0, 16'sd0},
    '{12'd2049, 12'd4095, 1'b0, 16'sd0},
    '{12'd2047, 12'd4095, 1'b0, 16'sd0},
    '{12'd4095, 12'd2047, 1'b0, 16'sd0},
    '{12'd0,    12'd2049, 1'b0, 16'sd0},
    '{12'd2049, 12'd2048, 1'b0, 16'sd0},
    '{12'd2047, 12'd2047, 1'b0, 16'sd0},
    '{12'd1234, 12'd3000, 1'b0, 16'sd0},
    '{12'd3500, 12'd700,  1'b0, 16'sd0}
  };

  angle_rec_t        pending_angles [$];
  angle_rec_t        head_rec;
  logic [S_BITS-1:0] mid_offset_now = 12'd2048;
  int                n_errors = 0;
  int                n_checked = 0;
  int                n_sent = 0;
  int                n_settings = 1;
  int                n_cycles = 0;

  always #5 clk = ~clk;

  sin_cos_to_angle_unit #(
    .CORDIC_STAGES (N_STAGES),
    .SAMPLE_BITS   (S_BITS)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_sin_sample (in_sin_sample),
    .in_cos_sample (in_cos_sample),
    .out_strobe    (out_strobe),
    .out_angle_deg (out_angle_deg),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  function automatic longint step_angle(input int idx);
    longint unsigned u;
    u = (atan_ndeg[idx] * (64'd1 << FRAC_BITS) + 64'd500000000) / 64'd1000000000;
    return longint'(u);
  endfunction

  function automatic logic signed [ANGLE_W-1:0] predict_angle(
    input logic [S_BITS-1:0] sin_raw, cos_raw, offset);
    longint sv, cv, x, y, z, dx, dy, r;
    sv = longint'(int'(sin_raw)) - longint'(int'(offset));
    cv = longint'(int'(cos_raw)) - longint'(int'(offset));
    if (sv == 0 && cv == 0) return '0;
    z = 0;
    if (cv < 0) begin
      if (sv >= 0) begin
        x = sv; y = -cv; z = 90 * (64'sd1 <<< FRAC_BITS);
      end else begin
        x = -sv; y = cv; z = -90 * (64'sd1 <<< FRAC_BITS);
      end
    end else begin
      x = cv; y = sv;
    end
    x = x <<< PRESCALE;
    y = y <<< PRESCALE;
    for (int i = 0; i < N_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + step_angle(i);
      end else begin
        x = x - dx; y = y + dy; z = z - step_angle(i);
      end
    end
    r = (z + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    if (r > SAT_LIMIT) r = SAT_LIMIT;
    if (r < -SAT_LIMIT) r = -SAT_LIMIT;
    return r[ANGLE_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= 40) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_angles.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing pending", out_angle_deg));
      end else begin
        head_rec = pending_angles.pop_front();
        n_checked++;
        if (out_angle_deg !== head_rec.angle)
          report_mismatch($sformatf("sin %0d cos %0d mid %0d: angle %0d, want %0d",
                          head_rec.sin_raw, head_rec.cos_raw, head_rec.offset,
                          out_angle_deg, head_rec.angle));
      end
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", n_cycles,
               pending_angles.size());
      $display("sin_cos_to_angle_unit test failed");
      $finish;
    end
  end

  task automatic send_pair(input logic [S_BITS-1:0] s, c, input logic typed,
                           input logic signed [ANGLE_W-1:0] typed_angle);
    angle_rec_t rec;
    in_sin_sample <= s;
    in_cos_sample <= c;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    rec.sin_raw = s;
    rec.cos_raw = c;
    rec.offset  = mid_offset_now;
    rec.angle   = typed ? typed_angle : predict_angle(s, c, mid_offset_now);
    pending_angles.push_back(rec);
    n_sent++;
  endtask

  task automatic hold_off(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_empty();
    start <= 1'b0;
    while (pending_angles.size() != 0) @(posedge clk);
  endtask

  task automatic write_offset(input logic [S_BITS-1:0] v);
    wait_empty();
    repeat (LATENCY + 2) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    mid_offset_now = v;
    n_settings++;
  endtask

  task automatic pick_pair(output logic [S_BITS-1:0] s, c);
    s = S_BITS'($urandom);
    c = S_BITS'($urandom);
    case ($urandom_range(0, 15))
      0: begin s = mid_offset_now; c = mid_offset_now; end
      1: s = mid_offset_now;
      2: c = mid_offset_now;
      3: begin
        s = $urandom_range(0, 1) ? '1 : '0;
        c = $urandom_range(0, 1) ? '1 : '0;
      end
      4: begin
        s = mid_offset_now + S_BITS'($urandom_range(0, 8)) - S_BITS'(4);
        c = mid_offset_now + S_BITS'($urandom_range(0, 8)) - S_BITS'(4);
      end
      default: ;
    endcase
  endtask

  task automatic run_random(input int n_items);
    int left, burst;
    logic [S_BITS-1:0] s, c;
    left = n_items;
    while (left > 0) begin
      burst = $urandom_range(1, 32);
      if (burst > left) burst = left;
      repeat (burst) begin
        pick_pair(s, c);
        send_pair(s, c, 1'b0, '0);
      end
      left -= burst;
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 6));
    end
  endtask

  initial begin
    logic [S_BITS-1:0] next_offset;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++)
      send_pair(dir_rows[i].sin_raw, dir_rows[i].cos_raw, dir_rows[i].typed,
                dir_rows[i].angle);

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0:       next_offset = '0;
        1:       next_offset = '1;
        2:       next_offset = 12'd2048;
        3:       next_offset = 12'd1;
        4:       next_offset = 12'd4094;
        default: next_offset = S_BITS'($urandom);
      endcase
      write_offset(next_offset);
      if (p == 2) begin
        run_random(ITEMS_PER_PHASE / 2);
        wait_empty();
        run_random(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 2);
      end else begin
        run_random(ITEMS_PER_PHASE);
      end
    end

    wait_empty();
    repeat (LATENCY + 4) @(posedge clk);
    $display("sent %0d sample pairs under %0d zero-level settings, %0d angles checked",
             n_sent, n_settings, n_checked);
    $display("mismatches: %0d", n_errors);
    if (n_errors == 0) begin
      $display("sin_cos_to_angle_unit test passed");
    end else begin
      $display("sin_cos_to_angle_unit test failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/sc2a_pkg.sv
rtl/core/sc2a_front.sv
rtl/core/sc2a_stage.sv
rtl/core/sc2a_back.sv
rtl/core/sin_cos_to_angle_unit.sv
tb/tb_top.sv
